>>> sv/cursor_overlay_alpha_blend_defines.svh
// assertion macros for the cursor overlay block
// no dependencies; included by files that carry concurrent checks
`ifndef CURSOR_OVERLAY_ALPHA_BLEND_DEFINES_SVH
`define CURSOR_OVERLAY_ALPHA_BLEND_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define COAB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("coab check failed");
// antecedent implies consequent in the next cycle
`define COAB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("coab check failed");
`else
`define COAB_ASSERT_NOW(lbl, ante, cons)
`define COAB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> sv/coab_pkg.sv
// shared constants, types and helper functions of the cursor overlay block
// no dependencies
`default_nettype none

package coab_pkg;

    localparam int CURSOR_DIM_MAX = 64;
    localparam int CURSOR_AW      = $clog2(CURSOR_DIM_MAX);
    localparam int STORE_AW       = 2 * CURSOR_AW;
    localparam int STORE_DEPTH    = CURSOR_DIM_MAX * CURSOR_DIM_MAX;
    localparam int IMAGE_DIM_MAX  = 16384;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // register indexes
    localparam logic [2:0] REG_FORMAT_MODE = 3'd0;
    localparam logic [2:0] REG_ORIGIN_X    = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Y    = 3'd2;
    localparam logic [2:0] REG_CURSOR_COLS = 3'd3;
    localparam logic [2:0] REG_CURSOR_ROWS = 3'd4;

    // format modes
    localparam logic [1:0] FMT_R2G1B0 = 2'd0;
    localparam logic [1:0] FMT_R0G1B2 = 2'd1;
    localparam logic [1:0] FMT_R3G2B1 = 2'd2;
    localparam logic [1:0] FMT_R1G2B3 = 2'd3;
    localparam logic [2:0] FMT_LAST_BLEND = {1'b0, FMT_R1G2B3};

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [15:0] ROUND_BIAS  = 16'd127;

    typedef struct packed {
        logic [2:0]  format_mode;
        logic [14:0] origin_x;
        logic [14:0] origin_y;
        logic [6:0]  cursor_cols;
        logic [6:0]  cursor_rows;
    } cfg_t;

    typedef struct packed {
        logic                is_load;
        logic [STORE_AW-1:0] addr;
        logic [31:0]         data;
        logic                covered;
        logic [1:0]          mode;
    } q_entry_t;

    typedef struct packed {
        logic          full;
        logic          empty;
        logic [Q_AW:0] count;
    } q_status_t;

    function automatic logic [1:0] red_pos(input logic [1:0] mode);
        logic [1:0] p;
        unique case (mode)
            FMT_R2G1B0: p = 2'd2;
            FMT_R0G1B2: p = 2'd0;
            FMT_R3G2B1: p = 2'd3;
            FMT_R1G2B3: p = 2'd1;
        endcase
        return p;
    endfunction

    function automatic logic [1:0] green_pos(input logic [1:0] mode);
        logic [1:0] p;
        unique case (mode)
            FMT_R2G1B0: p = 2'd1;
            FMT_R0G1B2: p = 2'd1;
            FMT_R3G2B1: p = 2'd2;
            FMT_R1G2B3: p = 2'd2;
        endcase
        return p;
    endfunction

    function automatic logic [1:0] blue_pos(input logic [1:0] mode);
        logic [1:0] p;
        unique case (mode)
            FMT_R2G1B0: p = 2'd0;
            FMT_R0G1B2: p = 2'd2;
            FMT_R3G2B1: p = 2'd1;
            FMT_R1G2B3: p = 2'd3;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] byte_get(input logic [31:0] w, input logic [1:0] pos);
        return w[{pos, 3'b000} +: 8];
    endfunction

    function automatic logic [31:0] byte_put(input logic [31:0] w, input logic [1:0] pos,
                                             input logic [7:0] b);
        logic [31:0] r;
        r = w;
        r[{pos, 3'b000} +: 8] = b;
        return r;
    endfunction

    // x / 255 for x below 255*256, by reciprocal with correction
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

>>> sv/coab_in_if.sv
// input channel: load and pixel words with valid/ready
// depends on coab_pkg
`default_nettype none

interface coab_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [coab_pkg::STORE_AW-1:0] cursor_addr;
    logic [31:0]                   cursor_argb;
    logic [13:0]                   pixel_x;
    logic [13:0]                   pixel_y;
    logic [31:0]                   pixel_in;

    modport source (output valid, action, cursor_addr, cursor_argb, pixel_x, pixel_y,
                    pixel_in, input ready);
    modport sink (input valid, action, cursor_addr, cursor_argb, pixel_x, pixel_y,
                  pixel_in, output ready);
endinterface

`default_nettype wire

>>> sv/coab_out_if.sv
// output channel: blended pixel words with valid/ready
// no dependencies
`default_nettype none

interface coab_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_out;
    logic        covered;

    modport source (output valid, pixel_out, covered, input ready);
    modport sink (input valid, pixel_out, covered, output ready);
endinterface

`default_nettype wire

>>> sv/coab_front.sv
// front end: accepts input words, tests the cursor rectangle, forms queue entries
// depends on coab_pkg and coab_in_if
`default_nettype none

module coab_front (
    coab_in_if.sink             in_ch,
    input  coab_pkg::cfg_t      cfg,
    input  logic                q_full,
    output logic                push,
    output coab_pkg::q_entry_t  entry
);

    logic [15:0] dx;
    logic [15:0] dy;
    logic [6:0]  cols_c;
    logic [6:0]  rows_c;
    logic        mode_ok;
    logic        in_image;
    logic        in_rect;

    assign in_ch.ready = !q_full;
    assign push        = in_ch.valid && !q_full;

    always_comb
    begin
        cols_c = (cfg.cursor_cols > 7'(coab_pkg::CURSOR_DIM_MAX)) ?
                 7'(coab_pkg::CURSOR_DIM_MAX) : cfg.cursor_cols;
        rows_c = (cfg.cursor_rows > 7'(coab_pkg::CURSOR_DIM_MAX)) ?
                 7'(coab_pkg::CURSOR_DIM_MAX) : cfg.cursor_rows;
        // offsets into the cursor image, sign in bit 15
        dx = {2'b00, in_ch.pixel_x} - {cfg.origin_x[14], cfg.origin_x};
        dy = {2'b00, in_ch.pixel_y} - {cfg.origin_y[14], cfg.origin_y};
        mode_ok  = cfg.format_mode <= coab_pkg::FMT_LAST_BLEND;
        in_image = ({1'b0, in_ch.pixel_x} < 15'(coab_pkg::IMAGE_DIM_MAX)) &&
                   ({1'b0, in_ch.pixel_y} < 15'(coab_pkg::IMAGE_DIM_MAX));
        in_rect  = !dx[15] && !dy[15] && (dx[14:0] < {8'b0, cols_c}) &&
                   (dy[14:0] < {8'b0, rows_c});

        entry.is_load = (in_ch.action == coab_pkg::ACT_LOAD);
        entry.mode    = cfg.format_mode[1:0];
        if (in_ch.action == coab_pkg::ACT_LOAD)
        begin
            entry.addr    = in_ch.cursor_addr;
            entry.data    = in_ch.cursor_argb;
            entry.covered = 1'b0;
        end
        else
        begin
            entry.addr    = {dy[coab_pkg::CURSOR_AW-1:0], dx[coab_pkg::CURSOR_AW-1:0]};
            entry.data    = in_ch.pixel_in;
            entry.covered = mode_ok && in_image && in_rect;
        end
    end

endmodule

`default_nettype wire

>>> sv/coab_queue.sv
// short fifo between front and back ends
// depends on coab_pkg
`default_nettype none

module coab_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  coab_pkg::q_entry_t   push_entry,
    input  logic                 pop,
    output coab_pkg::q_entry_t   head,
    output coab_pkg::q_status_t  status
);

    coab_pkg::q_entry_t          slot_reg [coab_pkg::Q_DEPTH];
    logic [coab_pkg::Q_AW-1:0]   wr_ptr_reg;
    logic [coab_pkg::Q_AW-1:0]   wr_ptr_next;
    logic [coab_pkg::Q_AW-1:0]   rd_ptr_reg;
    logic [coab_pkg::Q_AW-1:0]   rd_ptr_next;
    logic [coab_pkg::Q_AW:0]     count_reg;
    logic [coab_pkg::Q_AW:0]     count_next;

    assign head          = slot_reg[rd_ptr_reg];
    assign status.count  = count_reg;
    assign status.empty  = (count_reg == '0);
    assign status.full   = (count_reg == (coab_pkg::Q_AW+1)'(coab_pkg::Q_DEPTH));

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {{coab_pkg::Q_AW{1'b0}}, push}
                                - {{coab_pkg::Q_AW{1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

>>> sv/coab_back.sv
// back end: cursor store, channel multiply, divide by 255 and byte merge
// depends on coab_pkg and coab_out_if
`default_nettype none

module coab_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  coab_pkg::q_entry_t   head,
    input  logic                 q_empty,
    output logic                 pop,
    coab_out_if.source           out_ch
);

    logic [31:0] store_reg [coab_pkg::STORE_DEPTH];

    logic        adv;

    // stage 1: store read
    logic        s1_valid_reg;
    logic [31:0] s1_cur_reg;
    logic [31:0] s1_pix_reg;
    logic        s1_cov_reg;
    logic [1:0]  s1_mode_reg;

    // stage 2: products
    logic        s2_valid_reg;
    logic [15:0] s2_prod_reg [3];
    logic [7:0]  s2_chan_reg [3];
    logic        s2_opaque_reg;
    logic [31:0] s2_pix_reg;
    logic        s2_cov_reg;
    logic [1:0]  s2_mode_reg;

    logic        out_valid_reg;
    logic [31:0] out_pix_reg;
    logic        out_cov_reg;

    logic [1:0]  s1_pos   [3];
    logic [15:0] prod_next [3];
    logic [1:0]  s2_pos   [3];
    logic [7:0]  chan_new [3];
    logic [31:0] merged;

    assign adv = !out_valid_reg || out_ch.ready;
    assign pop = adv && !q_empty;

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.pixel_out = out_pix_reg;
    assign out_ch.covered   = out_cov_reg;

    always_comb
    begin
        // channel order: red, green, blue
        s1_pos[0] = coab_pkg::red_pos(s1_mode_reg);
        s1_pos[1] = coab_pkg::green_pos(s1_mode_reg);
        s1_pos[2] = coab_pkg::blue_pos(s1_mode_reg);
        for (int k = 0; k < 3; k++)
        begin
            prod_next[k] = {8'b0, coab_pkg::byte_get(s1_pix_reg, s1_pos[k])} *
                           {8'b0, coab_pkg::ALPHA_OPAQUE - s1_cur_reg[31:24]};
        end
    end

    always_comb
    begin
        s2_pos[0] = coab_pkg::red_pos(s2_mode_reg);
        s2_pos[1] = coab_pkg::green_pos(s2_mode_reg);
        s2_pos[2] = coab_pkg::blue_pos(s2_mode_reg);
        merged = s2_pix_reg;
        for (int k = 0; k < 3; k++)
        begin
            // sum wraps to eight bits
            chan_new[k] = s2_opaque_reg ? s2_chan_reg[k] :
                          coab_pkg::div255(s2_prod_reg[k] + coab_pkg::ROUND_BIAS) +
                          s2_chan_reg[k];
            merged = coab_pkg::byte_put(merged, s2_pos[k], chan_new[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= pop && !head.is_load;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.is_load)
        begin
            store_reg[head.addr] <= head.data;
        end
        if (adv)
        begin
            s1_cur_reg  <= store_reg[head.addr];
            s1_pix_reg  <= head.data;
            s1_cov_reg  <= head.covered;
            s1_mode_reg <= head.mode;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s2_prod_reg[k] <= prod_next[k];
            end
            s2_chan_reg[0] <= s1_cur_reg[23:16];
            s2_chan_reg[1] <= s1_cur_reg[15:8];
            s2_chan_reg[2] <= s1_cur_reg[7:0];
            s2_opaque_reg  <= (s1_cur_reg[31:24] == coab_pkg::ALPHA_OPAQUE);
            s2_pix_reg     <= s1_pix_reg;
            s2_cov_reg     <= s1_cov_reg;
            s2_mode_reg    <= s1_mode_reg;

            out_pix_reg <= s2_cov_reg ? merged : s2_pix_reg;
            out_cov_reg <= s2_cov_reg;
        end
    end

endmodule

`default_nettype wire

>>> sv/cursor_overlay_alpha_blend.sv
// top level of the cursor overlay block: configuration registers, front, queue, back
// depends on coab_pkg, coab_in_if, coab_out_if, coab_front, coab_queue, coab_back
`default_nettype none

`include "cursor_overlay_alpha_blend_defines.svh"

// Overlays a premultiplied-alpha cursor on a pixel stream. One input word (cursor load
// or screen pixel) is taken every cycle while the output side drains; a pixel word
// goes from the queue through the registered stages store read, channel multiply, and
// divide and byte merge to its output word; loads give none. A stalled output
// fills the four-entry queue, after which ready drops. The rate is set by the single
// cursor store port, which serves one load write or one pixel read per cycle. The
// store has no reset or clearing pass: pixels must only hit entries that were loaded.
// Write configuration only while the block is idle.
module cursor_overlay_alpha_blend (
    input  logic        clk,
    input  logic        rst_n,
    coab_in_if.sink     in_ch,
    coab_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_data
);

    coab_pkg::cfg_t      cfg_reg;
    coab_pkg::cfg_t      cfg_next;
    coab_pkg::q_entry_t  push_entry;
    coab_pkg::q_entry_t  head;
    coab_pkg::q_status_t q_stat;
    logic                push;
    logic                pop;
    logic                mode_blends;

    assign mode_blends = cfg_reg.format_mode <= coab_pkg::FMT_LAST_BLEND;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                coab_pkg::REG_FORMAT_MODE: cfg_next.format_mode = cfg_data[2:0];
                coab_pkg::REG_ORIGIN_X:    cfg_next.origin_x    = cfg_data;
                coab_pkg::REG_ORIGIN_Y:    cfg_next.origin_y    = cfg_data;
                coab_pkg::REG_CURSOR_COLS: cfg_next.cursor_cols = cfg_data[6:0];
                coab_pkg::REG_CURSOR_ROWS: cfg_next.cursor_rows = cfg_data[6:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    coab_front u_front (
        .in_ch  (in_ch),
        .cfg    (cfg_reg),
        .q_full (q_stat.full),
        .push   (push),
        .entry  (push_entry)
    );

    coab_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_stat)
    );

    coab_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_stat.empty),
        .pop     (pop),
        .out_ch  (out_ch)
    );

    `COAB_ASSERT_NOW(a_no_push_when_full, push, !q_stat.full)
    `COAB_ASSERT_NEXT(a_accept_fills_queue, in_ch.valid && in_ch.ready, !q_stat.empty)
    `COAB_ASSERT_NOW(a_cover_needs_mode, out_ch.valid && out_ch.covered, mode_blends)

endmodule

`default_nettype wire
